// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RWR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define RWR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/rwr_pkg.sv =====
package rwr_pkg;

  // fixed field and datapath widths
  localparam int CoordW = 8;
  localparam int DimW   = 9;
  localparam int ProdW  = 18;
  localparam int NumW   = 19;
  localparam int DenW   = 10;
  localparam int QuoW   = 9;
  localparam int PixW   = 24;

  // register indexes on the config port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // one item as it travels down the pipeline
  typedef struct packed {
    op_t               op;
    logic              in_frame;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   pix;
  } item_t;

  // front end to divider
  typedef struct packed {
    item_t             item;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
    logic [DimW-1:0]   h;
  } front_t;

  // divider to frame store
  typedef struct packed {
    item_t             item;
    logic [DimW-1:0]   src;
  } warp_t;

endpackage

// ===== hw/rtl/rwr_front.sv =====
`include "assert_macros.svh"

module rwr_front #(
  parameter int MAX_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [rwr_pkg::DimW-1:0]    cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rwr_pkg::op_t                in_op,
  input  logic [rwr_pkg::CoordW-1:0]  in_row,
  input  logic [rwr_pkg::CoordW-1:0]  in_col,
  input  logic [rwr_pkg::PixW-1:0]    in_pix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rwr_pkg::front_t             out_data
);
  import rwr_pkg::*;

  localparam logic [10:0] MaxDimL = 11'(MAX_DIM);

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    if ({2'b00, v} > MaxDimL) begin
      clamp_dim = DimW'(MAX_DIM);
    end else begin
      clamp_dim = v;
    end
  endfunction

  logic [DimW-1:0] width_r, height_r;

  // frame size, kept already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_dim(9'd256);
      height_r <= clamp_dim(9'd256);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:  width_r  <= clamp_dim(cfg_wdata);
        CFG_HEIGHT: height_r <= clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  // elastic stage control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !s3_v_r || out_ready;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  // stage 1: range check and |2*row - h|
  logic [DimW-1:0] two_row;
  logic            neg_c;
  logic [DimW-1:0] ad_c;
  logic            inside_c;

  assign two_row  = {in_row, 1'b0};
  assign neg_c    = two_row < height_r;
  assign ad_c     = neg_c ? (height_r - two_row) : (two_row - height_r);
  assign inside_c = ({1'b0, in_row} < height_r) && ({1'b0, in_col} < width_r);

  item_t           s1_item_r;
  logic [DimW-1:0] s1_ad_r, s1_h_r;
  logic            s1_neg_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_item_r <= '{op: in_op, in_frame: inside_c, row: in_row, col: in_col, pix: in_pix};
      s1_ad_r   <= ad_c;
      s1_h_r    <= height_r;
      s1_neg_r  <= neg_c;
    end
  end

  // stage 2: squares
  logic [ProdW-1:0] hh_c, dd_c;
  assign hh_c = ProdW'(s1_h_r) * ProdW'(s1_h_r);
  assign dd_c = ProdW'(s1_ad_r) * ProdW'(s1_ad_r);

  item_t            s2_item_r;
  logic [ProdW-1:0] s2_hh_r, s2_dd_r;
  logic [DimW-1:0]  s2_h_r;
  logic             s2_neg_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_item_r <= s1_item_r;
      s2_hh_r   <= hh_c;
      s2_dd_r   <= dd_c;
      s2_h_r    <= s1_h_r;
      s2_neg_r  <= s1_neg_r;
    end
  end

  // stage 3: numerator and denominator
  logic [NumW-1:0] num_c;
  assign num_c = s2_neg_r ? ({1'b0, s2_hh_r} - {1'b0, s2_dd_r})
                          : ({1'b0, s2_hh_r} + {1'b0, s2_dd_r});

  front_t s3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r <= '{item: s2_item_r, num: num_c, den: {s2_h_r, 1'b0}, h: s2_h_r};
    end
  end

  assign out_valid = s3_v_r;
  assign out_data  = s3_r;

  // a blocked first stage keeps its item
  `RWR_ASSERT_NXT(a_s1_hold, s1_v_r && !rdy2, s1_v_r && $stable(s1_item_r))

endmodule

// ===== hw/rtl/rwr_div.sv =====
`include "assert_macros.svh"

module rwr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rwr_pkg::front_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rwr_pkg::warp_t   out_data
);
  import rwr_pkg::*;

  localparam int Steps = QuoW;

  typedef struct packed {
    item_t           item;
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [DimW-1:0] h;
    logic [QuoW-1:0] quo;
  } div_t;

  logic [Steps-1:0] v_r;
  div_t             st_r  [Steps];
  div_t             src_s [Steps];
  div_t             nxt_s [Steps];
  logic [NumW-1:0]  dsh   [Steps];
  logic [Steps-1:0] src_v;
  logic [Steps:0]   rdy;
  logic             rnd_v_r;
  warp_t            rnd_r;

  // ready ripples back through the stages
  assign rdy[Steps] = !rnd_v_r || out_ready;
  assign in_ready   = rdy[0];

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 0; k < Steps; k++) begin : g_stage
    localparam int Sh = Steps - 1 - k;

    if (k == 0) begin : g_first
      assign src_s[k] = '{item: in_data.item, rem: in_data.num, den: in_data.den,
                          h: in_data.h, quo: '0};
      assign src_v[k] = in_valid;
    end else begin : g_next
      assign src_s[k] = st_r[k-1];
      assign src_v[k] = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign dsh[k] = {{(NumW-DenW){1'b0}}, src_s[k].den} << Sh;

    always_comb begin
      nxt_s[k] = src_s[k];
      if (src_s[k].rem >= dsh[k]) begin
        nxt_s[k].rem     = src_s[k].rem - dsh[k];
        nxt_s[k].quo[Sh] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < Steps; k++) begin
        if (rdy[k]) v_r[k] <= src_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Steps; k++) begin
      if (rdy[k]) st_r[k] <= nxt_s[k];
    end
  end

  // nearest row: round up past half, never beyond the last row
  div_t            last;
  logic [DenW-1:0] rmd;
  logic [DenW-1:0] q_inc;
  logic            up_c;
  logic [DimW-1:0] src_c;

  assign last  = st_r[Steps-1];
  assign rmd   = last.rem[DenW-1:0];
  assign q_inc = {1'b0, last.quo} + 10'd1;
  assign up_c  = ({rmd, 1'b0} > {1'b0, last.den}) && (q_inc < {1'b0, last.h});
  assign src_c = up_c ? q_inc[DimW-1:0] : last.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else if (rdy[Steps]) begin
      rnd_v_r <= v_r[Steps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[Steps]) begin
      rnd_r <= '{item: last.item, src: src_c};
    end
  end

  assign out_valid = rnd_v_r;
  assign out_data  = rnd_r;

  // an in-frame item always maps to a row inside the frame
  `RWR_ASSERT_NXT(a_src_in_frame, rdy[Steps] && v_r[Steps-1] && last.item.in_frame,
                  rnd_r.src < $past(last.h))

endmodule

// ===== hw/rtl/rwr_frame.sv =====
`include "assert_macros.svh"

module rwr_frame #(
  parameter int MAX_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rwr_pkg::warp_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rwr_pkg::PixW-1:0]    out_pix,
  output logic [rwr_pkg::CoordW-1:0]  out_src,
  output logic                        out_oor
);
  import rwr_pkg::*;

  // coordinates are 8 bits, so at most 256 rows and columns are ever stored
  localparam int CoordBits = (MAX_DIM > 256) ? CoordW : $clog2(MAX_DIM);
  localparam int AddrW     = 2 * CoordBits;
  localparam int Depth     = 1 << AddrW;

  logic [PixW-1:0] mem [Depth];

  logic                 v_r;
  logic [PixW-1:0]      rd_r;
  logic [CoordW-1:0]    src_r;
  logic                 oor_r;
  logic                 fetch_c;
  logic                 take_c;
  logic [CoordBits-1:0] row_sel;
  logic [AddrW-1:0]     addr_c;

  assign in_ready = !v_r || out_ready;
  assign take_c   = in_valid && in_ready;
  assign fetch_c  = in_data.item.op == OP_FETCH;
  assign row_sel  = fetch_c ? in_data.src[CoordBits-1:0] : in_data.item.row[CoordBits-1:0];
  assign addr_c   = {row_sel, in_data.item.col[CoordBits-1:0]};

  // one access per beat: fetches read, in-frame stores write
  always_ff @(posedge clk) begin
    if (take_c) begin
      if (fetch_c) begin
        rd_r <= mem[addr_c];
      end else if (in_data.item.in_frame) begin
        mem[addr_c] <= in_data.item.pix;
      end
    end
  end

  // output register; stores leave no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid && fetch_c;
    end
  end

  always_ff @(posedge clk) begin
    if (take_c) begin
      oor_r <= !in_data.item.in_frame;
      src_r <= in_data.item.in_frame ? in_data.src[CoordW-1:0] : '0;
    end
  end

  assign out_valid = v_r;
  assign out_pix   = oor_r ? '0 : rd_r;
  assign out_src   = src_r;
  assign out_oor   = oor_r;

  // a store beat never shows up as a result
  `RWR_ASSERT_NXT(a_store_silent, take_c && !fetch_c, !out_valid)

endmodule

// ===== hw/rtl/parabolic_row_warp_remap_top.sv =====
// Parabolic row-warp remap over an RGB frame store.
// Input stream (in_*): one beat per store or fetch. in_tuser is the opcode
// (0 store, 1 fetch); in_tdata carries row, column and the pixel to store.
// A store writes the frame store and returns nothing; stores outside the
// configured size are dropped. A fetch returns one beat on out_* with the
// pixel of the same column from the warped source row, the row used, and
// out_tuser set when the fetch lies outside the configured size (pixel and
// row then read as zero).
// Config port (cfg_*): index 0 is the width, 1 the height, each saturated to
// MAX_DIM. Write it only while the pipeline is empty.
// A fetch passes three front stages (range check, squares, numerator), nine
// divider stages at one quotient bit each, the rounding stage and the memory
// read register.
// Throughput: one beat per cycle while out_tready does not hold the pipeline,
// set by the single frame store port that each beat uses at most once.
// Reset clears the pipeline and sets both sizes to 256 (or MAX_DIM); frame
// contents are undefined until written, with no clearing pass.
// When out_tready is low, beats keep flowing into empty pipeline slots; only
// once every stage is full does in_tready drop.
module parabolic_row_warp_remap_top #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // row[7:0], column[15:8], red_in[23:16], green_in[31:24], blue_in[39:32]
  input  logic [39:0] in_tdata,
  // opcode[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], source_row[31:24]
  output logic [31:0] out_tdata,
  // out_of_range[0]
  output logic        out_tuser
);
  import rwr_pkg::*;

  logic            fr_valid, fr_ready;
  front_t          fr_data;
  logic            dv_valid, dv_ready;
  warp_t           dv_data;
  logic [PixW-1:0] pix_in;
  logic [PixW-1:0] pix_out;
  logic [CoordW-1:0] src_out;

  // stored as red, green, blue from the top bit down
  assign pix_in = {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]};

  rwr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (op_t'(in_tuser)),
    .in_row   (in_tdata[7:0]),
    .in_col   (in_tdata[15:8]),
    .in_pix   (pix_in),
    .out_valid(fr_valid),
    .out_ready(fr_ready),
    .out_data (fr_data)
  );

  rwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_valid),
    .in_ready (fr_ready),
    .in_data  (fr_data),
    .out_valid(dv_valid),
    .out_ready(dv_ready),
    .out_data (dv_data)
  );

  rwr_frame #(
    .MAX_DIM(MAX_DIM)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_valid),
    .in_ready (dv_ready),
    .in_data  (dv_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pix  (pix_out),
    .out_src  (src_out),
    .out_oor  (out_tuser)
  );

  assign out_tdata = {src_out, pix_out[7:0], pix_out[15:8], pix_out[23:16]};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rwr_pkg::*;

  localparam int FrameDim   = 256;
  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 200;

  // fetch result as it appears on the output stream
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] src_row;
    logic       oor;
  } warp_pixel_t;

  // Frame store mirror plus warp predictor; expected fetch results queue up in order.
  class warp_scoreboard;
    bit [23:0]   frame [FrameDim*FrameDim];
    bit [8:0]    width_reg  = 9'd256;
    bit [8:0]    height_reg = 9'd256;
    warp_pixel_t pixel_q [$];
    int          errors = 0;

    function int unsigned dim(bit [8:0] v);
      return (v > FrameDim) ? FrameDim : v;
    endfunction

    function bit is_inside(int unsigned row, int unsigned col);
      return row < dim(height_reg) && col < dim(width_reg);
    endfunction

    // parabolic row mapping, exact integer form, ties to the lower row
    function int unsigned source_row(int unsigned row);
      int unsigned h, two_row, ad, n, den, q, r;
      h       = dim(height_reg);
      two_row = 2 * row;
      ad      = (two_row >= h) ? two_row - h : h - two_row;
      n       = (two_row < h) ? h * h - ad * ad : h * h + ad * ad;
      den     = 2 * h;
      q       = n / den;
      r       = n % den;
      if (2 * r > den && q + 1 < h) q = q + 1;
      if (q >= h) q = h - 1;
      return q;
    endfunction

    function void write_reg(logic idx, bit [8:0] v);
      if (idx == CFG_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    // accepted input beat: stores update the mirror, fetches queue a result
    function void note_beat(op_t op, int unsigned row, int unsigned col, bit [23:0] pix);
      warp_pixel_t res;
      int unsigned src;
      if (op == OP_STORE) begin
        if (is_inside(row, col)) frame[row*FrameDim + col] = pix;
      end else begin
        res = '0;
        if (!is_inside(row, col)) begin
          res.oor = 1'b1;
        end else begin
          src         = source_row(row);
          res.src_row = src[7:0];
          {res.red, res.green, res.blue} = frame[src*FrameDim + col];
        end
        pixel_q.push_back(res);
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_beat(logic [31:0] data, logic oor);
      warp_pixel_t want;
      if (pixel_q.size() == 0) begin
        $error("result beat with no fetch pending: tdata %h tuser %b", data, oor);
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      compare_field("red_out", want.red, data[7:0]);
      compare_field("green_out", want.green, data[15:8]);
      compare_field("blue_out", want.blue, data[23:16]);
      compare_field("source_row", want.src_row, data[31:24]);
      compare_field("out_of_range", want.oor, oor);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  // row[7:0], column[15:8], red_in[23:16], green_in[31:24], blue_in[39:32]
  logic [39:0] in_tdata;
  // opcode[0]
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // red_out[7:0], green_out[15:8], blue_out[23:16], source_row[31:24]
  logic [31:0] out_tdata;
  // out_of_range[0]
  logic        out_tuser;

  warp_scoreboard sb = new();
  bit             pix_written [FrameDim*FrameDim];
  int             snd_idle_pct = 17;
  int             rcv_idle_pct = 54;
  bit             hold_req = 1'b0;
  int             cycle_count = 0;

  parabolic_row_warp_remap_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_beat(op_t'(in_tuser), in_tdata[7:0], in_tdata[15:8],
                     {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]});
      if (out_tvalid && out_tready)
        sb.check_beat(out_tdata, out_tuser);
    end
  end

  // receiver: random backpressure, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // one input beat; called and returns at a falling edge
  task automatic send_beat(op_t op, bit [7:0] row, bit [7:0] col, bit [23:0] pix);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {pix[7:0], pix[15:8], pix[23:16], col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic store_pixel(bit [7:0] row, bit [7:0] col, bit [23:0] pix);
    if (sb.is_inside(row, col)) pix_written[row*FrameDim + col] = 1'b1;
    send_beat(OP_STORE, row, col, pix);
  endtask

  // fetch; for an in-frame fetch, fills the source entry first if it was never written
  task automatic fetch_pixel(bit [7:0] row, bit [7:0] col);
    int unsigned src;
    if (sb.is_inside(row, col)) begin
      src = sb.source_row(row);
      if (!pix_written[src*FrameDim + col]) store_pixel(src[7:0], col, 24'($urandom));
    end
    send_beat(OP_FETCH, row, col, 24'($urandom));
  endtask

  // wait until every fetch has answered, then let trailing stores retire
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, bit [8:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_size(bit [8:0] w, bit [8:0] h);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic random_beat();
    int unsigned row_lim, col_lim, pick;
    row_lim = sb.dim(sb.height_reg) + 1;
    col_lim = sb.dim(sb.width_reg) + 1;
    if (row_lim > 255) row_lim = 255;
    if (col_lim > 255) col_lim = 255;
    pick = $urandom_range(99);
    if (pick < 45) begin
      fetch_pixel(8'($urandom_range(0, row_lim)), 8'($urandom_range(0, col_lim)));
    end else if (pick < 85) begin
      store_pixel(8'($urandom_range(0, row_lim)), 8'($urandom_range(0, col_lim)),
                  24'($urandom));
    end else begin
      // noise over the whole coordinate space
      if ($urandom_range(1)) fetch_pixel(8'($urandom), 8'($urandom));
      else store_pixel(8'($urandom), 8'($urandom), 24'($urandom));
    end
  endtask

  // stimulus
  initial begin
    int phase_w [8] = '{256, 16, 1, 9, 511, 200, 0, 64};
    int phase_h [8] = '{256, 16, 1, 4, 2, 3, 10, 256};
    int phase_n [8] = '{140, 140, 80, 140, 140, 140, 40, 140};
    int beat_no;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = OP_STORE;
    in_tdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: full frame corners and center
    store_pixel(8'd0, 8'd0, 24'hFFFFFF);
    store_pixel(8'd255, 8'd255, 24'h000000);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd255, 8'd255);
    fetch_pixel(8'd128, 8'd128);
    fetch_pixel(8'd255, 8'd0);
    // oversized width saturates; height 4 has a rounding tie at row 1
    set_size(9'd300, 9'd4);
    store_pixel(8'd200, 8'd10, 24'h123456);
    store_pixel(8'd3, 8'd255, 24'hA5A5A5);
    fetch_pixel(8'd1, 8'd7);
    fetch_pixel(8'd3, 8'd255);
    fetch_pixel(8'd4, 8'd0);
    fetch_pixel(8'd0, 8'd255);
    fetch_pixel(8'd255, 8'd3);
    // zero width: everything falls outside
    set_size(9'd0, 9'd4);
    store_pixel(8'd0, 8'd0, 24'h5A5A5A);
    fetch_pixel(8'd0, 8'd0);

    // random phases over a range of frame sizes
    beat_no = 0;
    for (int p = 0; p < 8; p++) begin
      set_size(9'(phase_w[p]), 9'(phase_h[p]));
      for (int i = 0; i < phase_n[p]; i++) begin
        if (beat_no < 350) begin
          snd_idle_pct = 17;
          rcv_idle_pct = 54;
        end else if (beat_no < 700) begin
          snd_idle_pct = 54;
          rcv_idle_pct = 17;
        end else begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        if (beat_no == 200 || beat_no == 800) hold_req = 1'b1;
        if (beat_no == 500) drain();
        random_beat();
        beat_no++;
      end
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rwr_pkg.sv
hw/rtl/rwr_front.sv
hw/rtl/rwr_div.sv
hw/rtl/rwr_frame.sv
hw/rtl/parabolic_row_warp_remap_top.sv
test/tb.sv
